[rtl/uartrx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants of the half-bit sampled 8N1 UART receiver.
// ----------------------------------------------------------------------------
package uartrx_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned PHASE_W = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_EN   = 1'b1;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_START      = 5'd1;
    localparam logic [PHASE_W-1:0] PH_DATA_FIRST = 5'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_LAST  = 5'd17;
    localparam logic [PHASE_W-1:0] PH_STOP       = 5'd19;

    typedef struct packed {
        logic              done;
        logic              ferr;
        logic              busy;
        logic [BYTE_W-1:0] data;
    } t_frame_evt;

endpackage : uartrx_pkg
`default_nettype wire

[rtl/uartrx_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_req_if
// Request channel: command and the three line samples of one tick.
// ----------------------------------------------------------------------------
interface uartrx_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       sample_first;
    logic       sample_second;
    logic       sample_third;

    modport source (
        output valid, command, sample_first, sample_second, sample_third,
        input  ready
    );
    modport sink (
        input  valid, command, sample_first, sample_second, sample_third,
        output ready
    );
endinterface : uartrx_req_if
`default_nettype wire

[rtl/uartrx_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_res_if
// Result channel: frame outcome, buffer slot and match flag.
// ----------------------------------------------------------------------------
interface uartrx_res_if #(
    parameter int unsigned IDX_W = 6
);
    logic             valid;
    logic             ready;
    logic             byte_done;
    logic [7:0]       data_byte;
    logic             stored;
    logic [IDX_W-1:0] write_index;
    logic             match_hit;
    logic             framing_error;
    logic             busy_res;

    modport source (
        output valid, byte_done, data_byte, stored, write_index, match_hit,
               framing_error, busy_res,
        input  ready
    );
    modport sink (
        input  valid, byte_done, data_byte, stored, write_index, match_hit,
               framing_error, busy_res,
        output ready
    );
endinterface : uartrx_res_if
`default_nettype wire

[rtl/uartrx_frame.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_frame
// Frame sequencer: half-bit phase counter, start/stop checks, byte assembly.
// ----------------------------------------------------------------------------
module uartrx_frame
    import uartrx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_s0,
    input  wire logic        i_s1,
    input  wire logic        i_s2,
    output t_frame_evt       o_evt
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic [2:0]         bit_idx;
    logic               data_phase;
    logic               done;
    logic               ferr;

    assign bit_idx    = 3'(r_phase[PHASE_W-1:1] - 4'd1);
    assign data_phase = (r_phase >= PH_DATA_FIRST) && (r_phase <= PH_DATA_LAST)
                        && r_phase[0];

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        done    = 1'b0;
        ferr    = 1'b0;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_EDGE: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase = PH_START;
                    end
                end
                CMD_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if ((i_s0 != i_s1) || (i_s0 != i_s2)) begin
                            n_shift = '0;
                        end
                        if (r_phase == PH_START) begin
                            if (!i_s0) begin
                                n_shift = '0;
                            end else begin
                                ferr = 1'b1;
                            end
                        end else if (data_phase) begin
                            if (i_s0) begin
                                n_shift[bit_idx] = 1'b1;
                            end
                        end else if (r_phase == PH_STOP) begin
                            if (i_s0) begin
                                done = 1'b1;
                            end else begin
                                ferr = 1'b1;
                            end
                        end
                        n_phase = (done || ferr) ? PH_IDLE : r_phase + 5'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_shift <= '0;
        end else begin
            r_phase <= n_phase;
            r_shift <= n_shift;
        end
    end

    assign o_evt.done = done;
    assign o_evt.ferr = ferr;
    assign o_evt.busy = (n_phase != PH_IDLE);
    assign o_evt.data = done ? n_shift : '0;

endmodule : uartrx_frame
`default_nettype wire

[rtl/uartrx_slot.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_slot
// Buffer slot allocation, receive count and match byte compare.
// ----------------------------------------------------------------------------
module uartrx_slot
    import uartrx_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = 64,
    parameter int unsigned IDX_W     = $clog2(BUF_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_clear,
    input  wire t_frame_evt            i_evt,
    output logic                       o_stored,
    output logic [IDX_W-1:0]           o_index,
    output logic                       o_hit
);

    localparam logic [IDX_W-1:0] COUNT_LIM = IDX_W'(BUF_DEPTH - 1);

    logic [IDX_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_match_byte;
    logic              r_match_en;

    assign o_stored = i_evt.done && (r_count < COUNT_LIM);
    assign o_index  = o_stored ? r_count : '0;
    assign o_hit    = o_stored && r_match_en && (i_evt.data == r_match_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (o_stored) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_byte <= '0;
            r_match_en   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH_BYTE: r_match_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_MATCH_EN:   r_match_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule : uartrx_slot
`default_nettype wire

[rtl/uartrx_obuf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_obuf
// Result register with a skid entry; takes one more request under back-pressure.
// ----------------------------------------------------------------------------
module uartrx_obuf #(
    parameter int unsigned DW = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_space,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [DW-1:0]      o_data
);

    logic          r_out_vld;
    logic          r_skid_vld;
    logic [DW-1:0] r_out;
    logic [DW-1:0] r_skid;
    logic          pop;

    assign pop     = r_out_vld && i_ready;
    assign o_space = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_push;
            end
        end else if (i_push) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (i_push) begin
            if (r_out_vld) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule : uartrx_obuf
`default_nettype wire

[rtl/uart_receiver_half_bit.sv]
// The result of an accepted request is registered in the result register, or in the skid entry while a result waits.
// Throughput: one request per cycle while the skid entry is free; the frame state updates in a single pass.
// A two-entry result stage (register plus skid) takes requests while a result waits.
// Reset (synchronous, active low) idles the phase counter, clears the byte,
// the receive count, both match registers and the result stage.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_receiver_half_bit
// 8N1 UART receiver driven by edge and half-bit tick requests.
// ----------------------------------------------------------------------------
module uart_receiver_half_bit
    import uartrx_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    uartrx_req_if.sink                 i_req,
    uartrx_res_if.source               o_res
);

    localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
    localparam int unsigned RES_W = BYTE_W + IDX_W + 5;

    logic             accept;
    logic             space;
    t_cmd             cmd;
    t_frame_evt       evt;
    logic             stored;
    logic [IDX_W-1:0] index;
    logic             hit;
    logic [RES_W-1:0] res_in;
    logic [RES_W-1:0] res_out;

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;
    assign cmd         = t_cmd'(i_req.command);

    uartrx_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_cmd   (cmd),
        .i_s0    (i_req.sample_first),
        .i_s1    (i_req.sample_second),
        .i_s2    (i_req.sample_third),
        .o_evt   (evt)
    );

    uartrx_slot #(
        .BUF_DEPTH(BUF_DEPTH),
        .IDX_W    (IDX_W)
    ) u_slot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_clear   (accept && (cmd == CMD_CLEAR)),
        .i_evt     (evt),
        .o_stored  (stored),
        .o_index   (index),
        .o_hit     (hit)
    );

    assign res_in = {evt.done, evt.data, stored, index, hit, evt.ferr, evt.busy};

    uartrx_obuf #(
        .DW(RES_W)
    ) u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (res_in),
        .o_space(space),
        .o_valid(o_res.valid),
        .i_ready(o_res.ready),
        .o_data (res_out)
    );

    assign {o_res.byte_done, o_res.data_byte, o_res.stored, o_res.write_index,
            o_res.match_hit, o_res.framing_error, o_res.busy_res} = res_out;

endmodule : uart_receiver_half_bit
`default_nettype wire

[rtl/uartrx_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uartrx_check
// Port-level checks on the result channel of the UART receiver.
// ----------------------------------------------------------------------------
module uartrx_check #(
    parameter int unsigned IDX_W = 6
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             i_ready,
    input wire logic             i_done,
    input wire logic [7:0]       i_data,
    input wire logic             i_stored,
    input wire logic [IDX_W-1:0] i_index,
    input wire logic             i_hit,
    input wire logic             i_ferr,
    input wire logic             i_busy
);

    a_stored_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_stored) |-> i_done)
        else $error("stored without completed byte");

    a_hit_needs_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_hit) |-> i_stored)
        else $error("match flag on a dropped byte");

    a_end_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_done || i_ferr)) |-> (!i_busy && !(i_done && i_ferr)))
        else $error("frame end while still busy or with both outcomes");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_stored) |-> (i_index == '0) && (i_done || (i_data == 8'd0)))
        else $error("index or byte nonzero without a stored or completed byte");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result dropped before it was taken");

endmodule : uartrx_check

bind uart_receiver_half_bit uartrx_check #(
    .IDX_W(IDX_W)
) u_check (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_res.valid),
    .i_ready(o_res.ready),
    .i_done (o_res.byte_done),
    .i_data (o_res.data_byte),
    .i_stored(o_res.stored),
    .i_index(o_res.write_index),
    .i_hit  (o_res.match_hit),
    .i_ferr (o_res.framing_error),
    .i_busy (o_res.busy_res)
);
`default_nettype wire

[tb/tb_uart_receiver_half_bit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_receiver_half_bit
// Drives edge, tick and clear requests into the half-bit UART receiver:
// whole 8N1 frames with random bytes, bad start and stop bits, disagreeing
// line samples and stray commands. A local frame tracker predicts every
// result, which is compared field by field as it leaves the block. Both
// handshakes idle at random, and the buffer count is driven up to full.
// ----------------------------------------------------------------------------
module tb_uart_receiver_half_bit;
    import uartrx_pkg::*;

    localparam int BUF_DEPTH    = 64;
    localparam int IDX_W        = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE       = 4;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic             done;
        logic [7:0]       data;
        logic             stored;
        logic [IDX_W-1:0] widx;
        logic             hit;
        logic             ferr;
        logic             busy;
    } t_rx_result;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    uartrx_req_if req_if ();
    uartrx_res_if #(.IDX_W(IDX_W)) res_if ();

    uart_receiver_half_bit #(
        .BUF_DEPTH (BUF_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // frame tracker
    logic [PHASE_W-1:0] rx_phase;
    logic [7:0]         rx_shift;
    logic [3:0]         rx_bit_idx;
    logic [IDX_W-1:0]   rx_count;
    logic [7:0]         cfg_match_byte;
    logic               cfg_match_en;

    t_rx_result pending_results[$];
    t_rx_result exp_r;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_active    = 1'b0;
    event hold_go;

    int req_count    = 0;
    int res_count    = 0;
    int fail_count   = 0;
    int done_seen    = 0;
    int stored_seen  = 0;
    int ferr_seen    = 0;
    int hit_seen     = 0;
    int idle_cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_rx_result next_rx_result(input t_cmd cmd, input logic s0,
                                                  input logic s1, input logic s2);
        t_rx_result r;
        r = '0;
        case (cmd)
            CMD_EDGE: begin
                if (rx_phase == PH_IDLE) rx_phase = PH_START;
            end
            CMD_TICK: begin
                if (rx_phase != PH_IDLE) begin
                    if (s0 != s1 || s0 != s2) rx_shift = '0;
                    if (rx_phase == PH_START) begin
                        if (!s0) begin
                            rx_shift   = '0;
                            rx_bit_idx = '0;
                        end else begin
                            r.ferr = 1'b1;
                        end
                    end else if (rx_phase >= PH_DATA_FIRST && rx_phase <= PH_DATA_LAST
                                 && rx_phase[0]) begin
                        if (s0 && rx_bit_idx < 4'd8) rx_shift[rx_bit_idx[2:0]] = 1'b1;
                        rx_bit_idx = rx_bit_idx + 4'd1;
                    end else if (rx_phase == PH_STOP) begin
                        if (s0) begin
                            r.done = 1'b1;
                            r.data = rx_shift;
                            if (rx_count < BUF_DEPTH - 1) begin
                                r.stored = 1'b1;
                                r.widx   = rx_count;
                                rx_count = rx_count + 1'b1;
                                r.hit    = (rx_shift == cfg_match_byte) && cfg_match_en;
                            end
                        end else begin
                            r.ferr = 1'b1;
                        end
                    end
                    rx_phase = (r.done || r.ferr) ? PH_IDLE : rx_phase + 5'd1;
                end
            end
            CMD_CLEAR: begin
                rx_count = '0;
            end
            default: ;
        endcase
        r.busy = (rx_phase != PH_IDLE);
        return r;
    endfunction

    function automatic void check_field(input string fname, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, fname, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // receiver side
    initial forever begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    always @(negedge clk) begin
        if (hold_active) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            res_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual byte %0h",
                         $time, res_if.data_byte);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("byte_done", exp_r.done, res_if.byte_done);
                check_field("data_byte", exp_r.data, res_if.data_byte);
                check_field("stored", exp_r.stored, res_if.stored);
                check_field("write_index", exp_r.widx, res_if.write_index);
                check_field("match_hit", exp_r.hit, res_if.match_hit);
                check_field("framing_error", exp_r.ferr, res_if.framing_error);
                check_field("busy_res", exp_r.busy, res_if.busy_res);
                done_seen   += exp_r.done;
                stored_seen += exp_r.stored;
                ferr_seen   += exp_r.ferr;
                hit_seen    += exp_r.hit;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // request side
    task automatic send_req(input t_cmd cmd, input logic s0, input logic s1, input logic s2);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= cmd;
        req_if.sample_first  <= s0;
        req_if.sample_second <= s1;
        req_if.sample_third  <= s2;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(next_rx_result(cmd, s0, s1, s2));
        req_count++;
    endtask

    task automatic send_tick(input logic line, input bit disagree);
        logic [1:0] others;
        others = {line, line};
        if (disagree) begin
            others = 2'($urandom_range(0, 3));
            if (others == {line, line}) others[$urandom_range(0, 1)] = ~line;
        end
        send_req(CMD_TICK, line, others[1], others[0]);
    endtask

    task automatic send_noise();
        int pick;
        t_cmd cmd;
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = CMD_TICK;
        else if (pick < 65) cmd = CMD_EDGE;
        else if (pick < 90) cmd = CMD_NONE;
        else cmd = CMD_CLEAR;
        send_req(cmd, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // edge, start bit, eight data bits LSB first, stop bit; two ticks per start and data bit, one for the stop bit
    task automatic send_frame(input logic [7:0] value, input bit bad_start, input bit bad_stop,
                              input bit stop_noise, input int noise_pct, input int stray_pct);
        logic line;
        send_req(CMD_EDGE, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        for (int ph = 1; ph <= 19; ph++) begin
            if (ph == 1) line = bad_start;
            else if (ph == 19) line = ~bad_stop;
            else if (ph % 2 == 1) line = value[(ph - 3) / 2];
            else line = $urandom_range(0, 1);
            if ($urandom_range(0, 99) < stray_pct)
                send_req($urandom_range(0, 1) ? CMD_EDGE : CMD_NONE, $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1));
            send_tick(line, (ph == 19) ? stop_noise : ($urandom_range(0, 99) < noise_pct));
            if (ph == 1 && bad_start) break;
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return cfg_match_byte;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MATCH_BYTE) cfg_match_byte = value;
        else cfg_match_en = value[0];
    endtask

    // tests
    task automatic test_idle_commands();
        send_tick(1'b1, 1'b1);
        send_req(CMD_NONE, 1'b1, 1'b1, 1'b1);
        send_req(CMD_CLEAR, 1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_frame_start();
        write_reg(CFG_MATCH_BYTE, 8'hFF);
        write_reg(CFG_MATCH_EN, 8'd1);
        send_req(CMD_EDGE, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        // re-arm, then hit a busy receiver with an edge and a count clear
        send_req(CMD_EDGE, 1'b0, 1'b0, 1'b0);
        send_req(CMD_CLEAR, 1'b1, 1'b1, 1'b1);
        send_frame(8'hFF, 1'b0, 1'b0, 1'b0, 0, 0);
        drain();
    endtask

    task automatic run_traffic(input int n_items);
        int first;
        first = req_count;
        while (req_count - first < n_items) begin
            if ($urandom_range(0, 99) < 10)
                send_noise();
            else
                send_frame(pick_byte(), $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 8,
                           $urandom_range(0, 99) < 10, 3, 2);
        end
        drain();
    endtask

    task automatic test_traffic_phases();
        write_reg(CFG_MATCH_BYTE, 8'h00);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(250);
        write_reg(CFG_MATCH_BYTE, 8'hFF);
        write_reg(CFG_MATCH_EN, 8'd0);
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        run_traffic(250);
        write_reg(CFG_MATCH_BYTE, 8'($urandom_range(0, 255)));
        write_reg(CFG_MATCH_EN, 8'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        run_traffic(250);
        write_reg(CFG_MATCH_BYTE, 8'($urandom_range(0, 255)));
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        run_traffic(250);
    endtask

    task automatic test_receiver_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (2) send_frame(pick_byte(), 1'b0, 1'b0, 1'b0, 0, 0);
        drain();
    endtask

    task automatic test_buffer_full();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        while (rx_count < BUF_DEPTH - 1)
            send_frame(pick_byte(), 1'b0, 1'b0, 1'b0, 0, 0);
        // dropped: no slot and no match flag
        repeat (2) send_frame(cfg_match_byte, 1'b0, 1'b0, 1'b0, 0, 0);
        send_req(CMD_CLEAR, 1'b0, 1'b1, 1'b0);
        send_frame(cfg_match_byte, 1'b0, 1'b0, 1'b0, 0, 0);
        drain();
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.command       = CMD_NONE;
        req_if.sample_first  = 1'b1;
        req_if.sample_second = 1'b1;
        req_if.sample_third  = 1'b1;
        res_if.ready         = 1'b0;
        rx_phase             = PH_IDLE;
        rx_shift             = '0;
        rx_bit_idx           = '0;
        rx_count             = '0;
        cfg_match_byte       = '0;
        cfg_match_en         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_commands();
        test_frame_start();
        test_traffic_phases();
        test_receiver_holdoff();
        test_buffer_full();

        repeat (10) @(posedge clk);
        $display("Sent %0d requests, checked %0d results: %0d bytes received, %0d stored, %0d dropped",
                 req_count, res_count, done_seen, stored_seen, done_seen - stored_seen);
        $display("Framing errors %0d, match hits %0d, field mismatches %0d",
                 ferr_seen, hit_seen, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : tb_uart_receiver_half_bit

[sim.f]
rtl/uartrx_pkg.sv
rtl/uartrx_req_if.sv
rtl/uartrx_res_if.sv
rtl/uartrx_frame.sv
rtl/uartrx_slot.sv
rtl/uartrx_obuf.sv
rtl/uart_receiver_half_bit.sv
rtl/uartrx_check.sv
tb/tb_uart_receiver_half_bit.sv
